// ===== sv/sle_pkg.sv =====
// Package for the sorted list engine: opcodes, status codes, default sizes
// and the command/status structs passed between controller and datapath.
// No dependencies.
package sle_pkg;

  localparam int unsigned SleDepth      = 16;
  localparam int unsigned SleValueWidth = 32;
  localparam int unsigned OpWidth       = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // read address source for the entry RAM
  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_DN = 2'd1,
    RD_IDX_UP = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic    load;          // capture opcode and key, clear index
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_to_count;
    logic    at_capture;    // record stop index and hit flag
    logic    hit_set;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_key;        // 1: key at stop index, 0: read data at index
    logic    cnt_inc;
    logic    cnt_dec;
    logic    stage_en;
    status_e stage_status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_srch;
    logic full;
    logic scan_end;
    logic cmp_ge;
    logic cmp_eq;
    logic hit;
    logic up_done;
    logic dn_done;
  } stat_t;

endpackage

// ===== sv/sle_if.sv =====
// Valid/ready channel interfaces for the sorted list engine.
// Depends on sle_pkg for default widths.
interface sle_in_if
  import sle_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = SleValueWidth
);
  logic                   valid;
  logic                   ready;
  logic [OpWidth-1:0]     opcode;
  logic [VALUE_WIDTH-1:0] key_value;

  modport source (output valid, output opcode, output key_value, input ready);
  modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

interface sle_out_if
  import sle_pkg::*;
#(
  parameter int unsigned CNT_WIDTH = $clog2(SleDepth + 1)
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           result_status;
  logic [CNT_WIDTH-1:0] result_position;
  logic [CNT_WIDTH-1:0] entry_count;

  modport source (output valid, output result_status, output result_position,
                  output entry_count, input ready);
  modport sink   (input valid, input result_status, input result_position,
                  input entry_count, output ready);
endinterface

// ===== sv/sle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sle_datapath.sv =====
// Datapath of the sorted list engine: entry RAM, index and fill counters,
// key compare and the result registers. Depends on sle_pkg and sle_ram.
module sle_datapath
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH       = SleDepth,
  parameter int unsigned VALUE_WIDTH = SleValueWidth,
  localparam int unsigned AW         = $clog2(DEPTH),
  localparam int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic [OpWidth-1:0]     opcode_i,
  input  logic [VALUE_WIDTH-1:0] key_value_i,
  output logic [1:0]             result_status_o,
  output logic [CW-1:0]          result_position_o,
  output logic [CW-1:0]          entry_count_o
);

  logic [OpWidth-1:0]     op_q;
  logic [VALUE_WIDTH-1:0] key_q;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          at_q;
  logic                   hit_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  status_e                res_status_q;
  logic [CW-1:0]          res_pos_q;
  logic [1:0]             out_status_q;
  logic [CW-1:0]          out_pos_q;
  logic [CW-1:0]          out_cnt_q;

  logic [CW-1:0]          idx_dn, idx_up;
  logic [AW-1:0]          raddr, waddr;
  logic [VALUE_WIDTH-1:0] wdata, rdata;

  assign idx_dn = idx_q - CW'(1);
  assign idx_up = idx_q + CW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:    raddr = idx_q[AW-1:0];
      RD_IDX_DN: raddr = idx_dn[AW-1:0];
      RD_IDX_UP: raddr = idx_up[AW-1:0];
      default:   raddr = idx_q[AW-1:0];
    endcase
  end

  assign waddr = cmd_i.wr_key ? at_q[AW-1:0] : idx_q[AW-1:0];
  assign wdata = cmd_i.wr_key ? key_q : rdata;

  sle_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.idx_to_count) begin
      idx_d = cnt_q;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_up;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_dn;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      key_q <= key_value_i;
    end
    if (cmd_i.at_capture) begin
      at_q  <= idx_q;
      hit_q <= cmd_i.hit_set;
    end
    if (cmd_i.stage_en) begin
      res_status_q <= cmd_i.stage_status;
      res_pos_q    <= (cmd_i.stage_status == ST_OK) ? at_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_cnt_q    <= cnt_q;
    end
  end

  always_comb begin
    stat_o.is_ins   = (op_q == OP_INSERT);
    stat_o.is_del   = (op_q == OP_DELETE);
    stat_o.is_srch  = (op_q == OP_SEARCH);
    stat_o.full     = (cnt_q == CW'(DEPTH));
    stat_o.scan_end = (idx_q == cnt_q);
    stat_o.cmp_ge   = ($signed(rdata) >= $signed(key_q));
    stat_o.cmp_eq   = (rdata == key_q);
    stat_o.hit      = hit_q;
    stat_o.up_done  = (idx_q == at_q);
    stat_o.dn_done  = (idx_up == cnt_q);
  end

  assign result_status_o   = out_status_q;
  assign result_position_o = out_pos_q;
  assign entry_count_o     = out_cnt_q;

endmodule

// ===== sv/sle_ctrl.sv =====
// Controller of the sorted list engine: sequences scan, shift and result
// steps and owns both handshakes. Depends on sle_pkg.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_SCAN     = 10'b00_0000_0010,
    S_SCAN_CMP = 10'b00_0000_0100,
    S_EVAL     = 10'b00_0000_1000,
    S_UP_RD    = 10'b00_0001_0000,
    S_UP_WR    = 10'b00_0010_0000,
    S_PUT      = 10'b00_0100_0000,
    S_DN_RD    = 10'b00_1000_0000,
    S_DN_WR    = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stat_i.is_ins && !stat_i.is_del && !stat_i.is_srch) begin
          cmd_o.stage_en     = 1'b1;
          cmd_o.stage_status = ST_NOT_FOUND;
          state_d            = S_DONE;
        end else if (stat_i.is_ins && stat_i.full) begin
          cmd_o.stage_en     = 1'b1;
          cmd_o.stage_status = ST_FULL;
          state_d            = S_DONE;
        end else if (stat_i.scan_end) begin
          // no entry at or above the key: stop at the end
          cmd_o.at_capture = 1'b1;
          state_d          = S_EVAL;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (stat_i.cmp_ge) begin
          cmd_o.at_capture = 1'b1;
          cmd_o.hit_set    = stat_i.cmp_eq;
          state_d          = S_EVAL;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN;
        end
      end

      S_EVAL: begin
        if (stat_i.is_ins) begin
          cmd_o.idx_to_count = 1'b1;
          state_d            = S_UP_RD;
        end else if (stat_i.hit && stat_i.is_del) begin
          state_d = S_DN_RD;
        end else if (stat_i.hit) begin
          cmd_o.stage_en     = 1'b1;
          cmd_o.stage_status = ST_OK;
          state_d            = S_DONE;
        end else begin
          cmd_o.stage_en     = 1'b1;
          cmd_o.stage_status = ST_NOT_FOUND;
          state_d            = S_DONE;
        end
      end

      // open a gap: move entries up from the top down to the stop index
      S_UP_RD: begin
        if (stat_i.up_done) begin
          state_d = S_PUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_DN;
          state_d      = S_UP_WR;
        end
      end

      S_UP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_UP_RD;
      end

      S_PUT: begin
        cmd_o.wr_en        = 1'b1;
        cmd_o.wr_key       = 1'b1;
        cmd_o.cnt_inc      = 1'b1;
        cmd_o.stage_en     = 1'b1;
        cmd_o.stage_status = ST_OK;
        state_d            = S_DONE;
      end

      // close the gap: move later entries down by one
      S_DN_RD: begin
        if (stat_i.dn_done) begin
          cmd_o.cnt_dec      = 1'b1;
          cmd_o.stage_en     = 1'b1;
          cmd_o.stage_status = ST_OK;
          state_d            = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_UP;
          state_d      = S_DN_WR;
        end
      end

      S_DN_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_DN_RD;
      end

      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: ascending store of signed values
// with insert, delete and search. Depends on sle_pkg, sle_if, sle_ctrl,
// sle_datapath and sle_ram.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-------------------------------------------
//   in_i    | in  | valid/ready       | opcode, key_value
//   out_o   | out | valid/ready       | result_status, result_position, entry_count
//
// One item at a time. An item runs a scan up to stop index p, one move per
// entry shifted and the overhead steps (accept, evaluate, last shift check,
// key write, result step), so an insert at the head of n stored entries is
// the worst case; the single read port of the entry RAM, one registered
// read per compare or move, sets this bound.
// Reset clears the fill count, the controller state and the output valid flag;
// the entry RAM is not cleared and no entry above the fill count is ever read.
// A finished result waits in the output register while the next item is
// accepted; a stalled output holds the engine before its result step.
module sorted_list_engine_top
  import sle_pkg::*;
#(
  parameter int unsigned DEPTH       = SleDepth,
  parameter int unsigned VALUE_WIDTH = SleValueWidth
) (
  input logic            clk_i,
  input logic            rst_ni,
  sle_in_if.sink         in_i,
  sle_out_if.source      out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t             cmd;
  stat_t            stat;
  logic [1:0]       res_status;
  logic [CW-1:0]    res_pos;
  logic [CW-1:0]    res_cnt;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sle_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .opcode_i          (in_i.opcode),
    .key_value_i       (in_i.key_value),
    .result_status_o   (res_status),
    .result_position_o (res_pos),
    .entry_count_o     (res_cnt)
  );

  assign out_o.result_status   = res_status;
  assign out_o.result_position = res_pos;
  assign out_o.entry_count     = res_cnt;

endmodule
